// ===== src/pwst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_pkg
// Shared constants, types and operation codes for the proximity window
// statistics tracker.
// ----------------------------------------------------------------------------
package pwst_pkg;

  // Block configuration.
  localparam int PROX_WINDOW   = 16;
  localparam int LIGHT_WINDOW  = 16;
  localparam int HISTORY_DEPTH = 32;
  localparam int TABLE_LEN     = 16;

  // Effective windows, clamped to the history ring.
  localparam int PW_EFF = (PROX_WINDOW < 1) ? 1 :
                          ((PROX_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : PROX_WINDOW);
  localparam int LW_EFF = (LIGHT_WINDOW < 1) ? 1 :
                          ((LIGHT_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : LIGHT_WINDOW);

  // Derived widths.
  localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1) + 1;
  localparam int SUM_W  = 16 + $clog2(HISTORY_DEPTH + 1);
  localparam int SQ_W   = 32 + $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int TI_W   = $clog2(TABLE_LEN);
  localparam int FILL_W = 6;
  localparam int FILL_MAX = 63;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int DEV_W    = 20;
  localparam int DIST_W   = 13;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 88;

  // Shared arithmetic unit.
  localparam int ROOT_W = 26;
  localparam int X_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W);

  localparam int MUL_A_W = (SQ_W > SUM_W) ? SQ_W : SUM_W;
  localparam int MUL_P_W = MUL_A_W + SUM_W;

  // Arithmetic operation codes.
  localparam logic ARITH_DIV  = 1'b0;
  localparam logic ARITH_SQRT = 1'b1;

  // Input item kinds.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TABLE  = 1'b1;

  // Register indexes.
  localparam logic REG_EXIT  = 1'b0;
  localparam logic REG_ENTER = 1'b1;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [X_W-1:0]    a;
    logic [15:0]       b;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } arith_rsp_t;

endpackage

// ===== src/pwst_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_arith
// Bit-serial divider and integer square root sharing one remainder datapath.
// Both take one result bit per cycle until all ROOT_W result bits are formed.
// ----------------------------------------------------------------------------
module pwst_arith (
  input  logic               clk,
  input  logic               rst,
  input  pwst_pkg::arith_req_t req,
  output pwst_pkg::arith_rsp_t rsp
);
  import pwst_pkg::*;

  logic              busy;
  logic              done;
  logic              op;
  logic [X_W-1:0]    x;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [15:0]       dvs;
  logic [STEP_W-1:0] step;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // One step: shift in one dividend bit or two radicand bits and try.
  always_comb begin
    if (op == ARITH_SQRT) begin
      rem_shift = {rem[REM_W-3:0], x[X_W-1 -: 2]};
      trial     = {root, 2'b01};
    end else begin
      rem_shift = {rem[REM_W-2:0], x[X_W-1]};
      trial     = REM_W'(dvs);
    end
    ge = (rem_shift >= trial);
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      x    <= (req.op == ARITH_DIV) ? {req.a[ROOT_W-1:0], {ROOT_W{1'b0}}} : req.a;
      dvs  <= req.b;
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? (rem_shift - trial) : rem_shift;
      root <= {root[ROOT_W-2:0], ge};
      x    <= (op == ARITH_SQRT) ? {x[X_W-3:0], 2'b00} : {x[X_W-2:0], 1'b0};
      step <= step + 1'b1;
    end
  end

  assign rsp.done   = done;
  assign rsp.result = root;

endmodule

// ===== src/proximity_window_stats_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_window_stats_tracker
// Window mean, deviation, distance and proximity flags for sensor samples.
// ----------------------------------------------------------------------------
// A sample transaction (tuser 0) updates the window sums, then reads, squares
// and accumulates each window entry for the sum of squares. Each channel then
// runs its multiply and setup states and three passes of the serial
// divide/square-root unit: square root, deviation divide and mean divide.
// After the second channel comes a walk of up to TABLE_LEN table entries and,
// when an entry after the first one matches, one more divide. s_tready is low
// during that time. A table transaction (tuser 1) is written from the idle
// state and gives no result. A finished result waits in the output register
// while the next transaction is taken.
// ----------------------------------------------------------------------------
module proximity_window_stats_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // prox_sample[15:0], light_sample[31:16], entry_index[35:32], entry_value[51:36]
  input  logic [pwst_pkg::IN_W-1:0]     s_tdata,
  // mode
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // prox_mean[15:0], prox_deviation[35:16], light_mean[51:36],
  // light_deviation[71:52], distance[84:72], near_flag[85], blocked_flag[86]
  output logic [pwst_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);
  import pwst_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SUM     = 4'd1;
  localparam logic [3:0] ST_SQ_RD   = 4'd2;
  localparam logic [3:0] ST_SQ_MP   = 4'd3;
  localparam logic [3:0] ST_SQ_ML   = 4'd4;
  localparam logic [3:0] ST_SQ_AL   = 4'd5;
  localparam logic [3:0] ST_M_NSQ   = 4'd6;
  localparam logic [3:0] ST_M_SS    = 4'd7;
  localparam logic [3:0] ST_M_SUB   = 4'd8;
  localparam logic [3:0] ST_SQRT_GO = 4'd9;
  localparam logic [3:0] ST_SQRT_W  = 4'd10;
  localparam logic [3:0] ST_DEV_W   = 4'd11;
  localparam logic [3:0] ST_MEAN_W  = 4'd12;
  localparam logic [3:0] ST_TBL     = 4'd13;
  localparam logic [3:0] ST_DIST_W  = 4'd14;
  localparam logic [3:0] ST_FIN     = 4'd15;

  logic [3:0] state;

  // Configuration registers.
  logic [15:0] exit_level;
  logic [15:0] enter_level;

  // Stored state.
  logic [SAMPLE_W-1:0] prox_mem  [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] light_mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] thr [TABLE_LEN];
  logic [SUM_W-1:0]    prox_sum;
  logic [SUM_W-1:0]    light_sum;
  logic [AW-1:0]       wp;
  logic [FILL_W-1:0]   fill;
  logic                near_state;
  logic                blocked_state;

  // Per-item working registers.
  logic [SAMPLE_W-1:0] ps;
  logic [SAMPLE_W-1:0] ls;
  logic [SAMPLE_W-1:0] rd_p;
  logic [SAMPLE_W-1:0] rd_l;
  logic [SQ_W-1:0]     acc_p;
  logic [SQ_W-1:0]     acc_l;
  logic [CNT_W-1:0]    k;
  logic                ch;
  logic [MUL_P_W-1:0]  prod;
  logic [NUM_W-1:0]    nsq;
  logic [NUM_W-1:0]    num;
  logic                light_flat;
  logic [SAMPLE_W-1:0] p_mean;
  logic [SAMPLE_W-1:0] l_mean;
  logic [DEV_W-1:0]    p_dev;
  logic [DEV_W-1:0]    l_dev;
  logic [TI_W-1:0]     ti;
  logic [SAMPLE_W-1:0] thr_prev;
  logic [DIST_W-1:0]   dist_val;

  logic                accept;
  logic [AW-1:0]       rd_addr_p;
  logic [AW-1:0]       rd_addr_l;
  logic [CNT_W-1:0]    n_p;
  logic [CNT_W-1:0]    n_l;
  logic [CNT_W-1:0]    n_max;
  logic [CNT_W-1:0]    n_ch;
  logic [SQ_W-1:0]     sq_ch;
  logic [SUM_W-1:0]    sum_ch;
  logic [MUL_A_W-1:0]  mul_a;
  logic [SUM_W-1:0]    mul_b;
  logic                near_next;
  logic                blocked_next;

  arith_req_t req;
  arith_rsp_t rsp;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Samples in each window, counting the current one.
  always_comb begin
    n_p   = ((CNT_W'(fill) + 1'b1) > CNT_W'(PW_EFF)) ? CNT_W'(PW_EFF) : CNT_W'(fill) + 1'b1;
    n_l   = ((CNT_W'(fill) + 1'b1) > CNT_W'(LW_EFF)) ? CNT_W'(LW_EFF) : CNT_W'(fill) + 1'b1;
    n_max = (n_p > n_l) ? n_p : n_l;
    n_ch  = ch ? n_l : n_p;
    sq_ch = ch ? acc_l : acc_p;
    sum_ch = ch ? light_sum : prox_sum;
  end

  // History read addresses: the leaving entry at accept, then walk backward.
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr_p = (int'(wp) >= PW_EFF) ? AW'(int'(wp) - PW_EFF)
                                       : AW'(int'(wp) + HISTORY_DEPTH - PW_EFF);
      rd_addr_l = (int'(wp) >= LW_EFF) ? AW'(int'(wp) - LW_EFF)
                                       : AW'(int'(wp) + HISTORY_DEPTH - LW_EFF);
    end else begin
      rd_addr_p = (int'(wp) >= int'(k)) ? AW'(int'(wp) - int'(k))
                                        : AW'(int'(wp) + HISTORY_DEPTH - int'(k));
      rd_addr_l = rd_addr_p;
    end
  end

  // History rings: read old contents before the write of the new sample.
  always_ff @(posedge clk) begin
    rd_p <= prox_mem[rd_addr_p];
    rd_l <= light_mem[rd_addr_l];
    if (accept && s_tuser == MODE_SAMPLE) begin
      prox_mem[wp]  <= s_tdata[15:0];
      light_mem[wp] <= s_tdata[31:16];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ_MP: begin
        mul_a = MUL_A_W'(rd_p);
        mul_b = SUM_W'(rd_p);
      end
      ST_SQ_ML: begin
        mul_a = MUL_A_W'(rd_l);
        mul_b = SUM_W'(rd_l);
      end
      ST_M_NSQ: begin
        mul_a = MUL_A_W'(sq_ch);
        mul_b = SUM_W'(n_ch);
      end
      ST_M_SS: begin
        mul_a = MUL_A_W'(sum_ch);
        mul_b = sum_ch;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // Requests to the serial divide/square-root unit.
  always_comb begin
    req = '0;
    if (state == ST_SQRT_GO) begin
      req.start = 1'b1;
      req.op    = ARITH_SQRT;
      req.a     = X_W'({num, 8'h00});
    end else if (state == ST_SQRT_W && rsp.done) begin
      req.start = 1'b1;
      req.op    = ARITH_DIV;
      req.a     = X_W'(rsp.result);
      req.b     = 16'(n_ch);
    end else if (state == ST_DEV_W && rsp.done) begin
      req.start = 1'b1;
      req.op    = ARITH_DIV;
      req.a     = X_W'(sum_ch);
      req.b     = 16'(n_ch);
    end else if (state == ST_TBL && p_mean >= thr[ti] && ti != '0) begin
      req.start = 1'b1;
      req.op    = ARITH_DIV;
      req.a     = X_W'({thr_prev - p_mean, 9'h000});
      req.b     = thr_prev - thr[ti];
    end
  end

  pwst_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Flag updates for the current sample.
  always_comb begin
    near_next = near_state;
    if (near_state && ps <= exit_level) begin
      near_next = 1'b0;
    end else if (!near_state && ps >= enter_level) begin
      near_next = 1'b1;
    end
    blocked_next = blocked_state;
    if (!blocked_state && near_next && l_mean == '0 && light_flat) begin
      blocked_next = 1'b1;
    end else if (blocked_state && !near_next) begin
      blocked_next = 1'b0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      exit_level  <= 16'h0000;
      enter_level <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXIT:  exit_level  <= cfg_data;
        REG_ENTER: enter_level <= cfg_data;
        default:   exit_level  <= exit_level;
      endcase
    end
  end

  // Threshold table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_LEN; i++) begin
        thr[i] <= '0;
      end
    end else if (accept && s_tuser == MODE_TABLE && int'(s_tdata[35:32]) < TABLE_LEN) begin
      thr[TI_W'(s_tdata[35:32])] <= s_tdata[51:36];
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      prox_sum      <= '0;
      light_sum     <= '0;
      wp            <= '0;
      fill          <= '0;
      near_state    <= 1'b0;
      blocked_state <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // The final state loads a new result itself, so only clear elsewhere.
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser == MODE_SAMPLE) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          prox_sum  <= prox_sum - ((int'(fill) >= PW_EFF) ? SUM_W'(rd_p) : '0) + SUM_W'(ps);
          light_sum <= light_sum - ((int'(fill) >= LW_EFF) ? SUM_W'(rd_l) : '0) + SUM_W'(ls);
          state     <= ST_SQ_RD;
        end
        ST_SQ_RD: state <= ST_SQ_MP;
        ST_SQ_MP: state <= ST_SQ_ML;
        ST_SQ_ML: state <= ST_SQ_AL;
        ST_SQ_AL: begin
          if (k + 1'b1 < n_max) begin
            state <= ST_SQ_RD;
          end else begin
            state <= ST_M_NSQ;
          end
        end
        ST_M_NSQ:   state <= ST_M_SS;
        ST_M_SS:    state <= ST_M_SUB;
        ST_M_SUB:   state <= ST_SQRT_GO;
        ST_SQRT_GO: state <= ST_SQRT_W;
        ST_SQRT_W: begin
          if (rsp.done) begin
            state <= ST_DEV_W;
          end
        end
        ST_DEV_W: begin
          if (rsp.done) begin
            state <= ST_MEAN_W;
          end
        end
        ST_MEAN_W: begin
          if (rsp.done) begin
            state <= ch ? ST_TBL : ST_M_NSQ;
          end
        end
        ST_TBL: begin
          if (p_mean >= thr[ti]) begin
            state <= (ti == '0) ? ST_FIN : ST_DIST_W;
          end else if (int'(ti) == TABLE_LEN - 1) begin
            state <= ST_FIN;
          end
        end
        ST_DIST_W: begin
          if (rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            near_state    <= near_next;
            blocked_state <= blocked_next;
            wp            <= (int'(wp) == HISTORY_DEPTH - 1) ? '0 : wp + 1'b1;
            fill          <= (int'(fill) == FILL_MAX) ? fill : fill + 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-item datapath registers.
  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_SAMPLE) begin
      ps <= s_tdata[15:0];
      ls <= s_tdata[31:16];
    end
    unique case (state)
      ST_SUM: begin
        acc_p <= '0;
        acc_l <= '0;
        k     <= '0;
        ch    <= 1'b0;
      end
      ST_SQ_ML: begin
        if (k < n_p) begin
          acc_p <= acc_p + SQ_W'(prod);
        end
      end
      ST_SQ_AL: begin
        if (k < n_l) begin
          acc_l <= acc_l + SQ_W'(prod);
        end
        k <= k + 1'b1;
      end
      ST_M_SS: nsq <= NUM_W'(prod);
      ST_M_SUB: num <= nsq - NUM_W'(prod);
      ST_SQRT_GO: begin
        if (ch) begin
          light_flat <= (num == '0);
        end
      end
      ST_DEV_W: begin
        if (rsp.done) begin
          if (ch) begin
            l_dev <= DEV_W'(rsp.result);
          end else begin
            p_dev <= DEV_W'(rsp.result);
          end
        end
      end
      ST_MEAN_W: begin
        if (rsp.done) begin
          if (ch) begin
            l_mean <= SAMPLE_W'(rsp.result);
          end else begin
            p_mean <= SAMPLE_W'(rsp.result);
          end
          ch       <= 1'b1;
          ti       <= '0;
          thr_prev <= '0;
        end
      end
      ST_TBL: begin
        if (p_mean >= thr[ti]) begin
          dist_val <= '0;
        end else begin
          if (int'(ti) == TABLE_LEN - 1) begin
            dist_val <= DIST_W'(512 * (TABLE_LEN - 1));
          end
          thr_prev <= thr[ti];
          ti       <= ti + 1'b1;
        end
      end
      ST_DIST_W: begin
        if (rsp.done) begin
          dist_val <= DIST_W'(512 * (int'(ti) - 1)) + DIST_W'(rsp.result[8:0]);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, blocked_next, near_next, dist_val, l_dev, l_mean, p_dev, p_mean};
    end
  end

endmodule

// ===== src/pwst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_checker
// Port-level checks for the proximity window statistics tracker.
// ----------------------------------------------------------------------------
module pwst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [pwst_pkg::OUT_W-1:0] m_tdata
);

  // A stalled result holds its data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A sample transaction makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("sample transaction did not start processing");

  // A new result only appears at the end of processing.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without processing");

  // No result right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind proximity_window_stats_tracker pwst_checker u_pwst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tb_proximity_window_stats_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proximity_window_stats_tracker
// Self-checking bench for the proximity window statistics tracker. Sample
// and table-write transactions are sent on the input stream while a
// behavioral copy of the window statistics, distance lookup and flag logic
// predicts each result, which is compared field by field on the output
// stream under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_proximity_window_stats_tracker;
  import pwst_pkg::*;

  typedef struct packed {
    logic [15:0] prox_mean;
    logic [19:0] prox_dev;
    logic [15:0] light_mean;
    logic [19:0] light_dev;
    logic [12:0] distance;
    logic        near_flag;
    logic        blocked_flag;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Predictor state.
  logic [15:0] prox_ring [HISTORY_DEPTH];
  logic [15:0] light_ring [HISTORY_DEPTH];
  logic [31:0] prox_total, light_total;
  int unsigned ring_ptr, seen_count;
  bit near_st, blocked_st;
  logic [15:0] thresholds [TABLE_LEN];
  logic [15:0] exit_lvl, enter_lvl;

  stats_t expected_q[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;

  proximity_window_stats_tracker u_top (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Mean and deviation of one channel, after the new sample is in the ring.
  task automatic channel_stats(input bit is_light, input longint unsigned total,
                               output longint unsigned mean,
                               output longint unsigned dev, output bit flat);
    longint unsigned n, sq, v, num;
    n = seen_count + 1;
    if (n > (is_light ? LW_EFF : PW_EFF)) n = is_light ? LW_EFF : PW_EFF;
    sq = 0;
    for (int k = 0; k < n; k++) begin
      v = is_light ? light_ring[(ring_ptr + HISTORY_DEPTH - k) % HISTORY_DEPTH]
                   : prox_ring[(ring_ptr + HISTORY_DEPTH - k) % HISTORY_DEPTH];
      sq += v * v;
    end
    num = n * sq - total * total;
    mean = total / n;
    dev = int_sqrt(num * 256) / n;
    flat = (num == 0);
  endtask

  function automatic longint unsigned distance_of(longint unsigned mean);
    longint unsigned hi, lo;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (mean >= thresholds[i]) begin
        if (i == 0) return 0;
        hi = thresholds[i-1];
        lo = thresholds[i];
        return 512 * (i - 1) + (512 * (hi - mean)) / (hi - lo);
      end
    end
    return 512 * (TABLE_LEN - 1);
  endfunction

  // Advance the predictor by one sample pair and queue the expected result.
  task automatic predict_sample(input logic [15:0] ps, input logic [15:0] ls);
    longint unsigned pm, pd, lm, ld;
    bit pf, lf;
    stats_t r;
    if (seen_count >= PW_EFF)
      prox_total -= prox_ring[(ring_ptr + HISTORY_DEPTH - PW_EFF) % HISTORY_DEPTH];
    prox_total += ps;
    prox_ring[ring_ptr] = ps;
    if (seen_count >= LW_EFF)
      light_total -= light_ring[(ring_ptr + HISTORY_DEPTH - LW_EFF) % HISTORY_DEPTH];
    light_total += ls;
    light_ring[ring_ptr] = ls;
    channel_stats(1'b0, prox_total, pm, pd, pf);
    channel_stats(1'b1, light_total, lm, ld, lf);
    if (near_st && ps <= exit_lvl) near_st = 0;
    else if (!near_st && ps >= enter_lvl) near_st = 1;
    if (!blocked_st && near_st && lm == 0 && lf) blocked_st = 1;
    else if (blocked_st && !near_st) blocked_st = 0;
    r.prox_mean = pm[15:0];
    r.prox_dev = pd[19:0];
    r.light_mean = lm[15:0];
    r.light_dev = ld[19:0];
    r.distance = 13'(distance_of(pm));
    r.near_flag = near_st;
    r.blocked_flag = blocked_st;
    expected_q.push_back(r);
    ring_ptr = (ring_ptr + 1) % HISTORY_DEPTH;
    if (seen_count < 63) seen_count++;
  endtask

  // Send one transaction and update the predictor once it is accepted.
  // tvalid stays high after acceptance until the next call or a pause
  // drives it again.
  task automatic send_item(input logic mode, input logic [15:0] ps, input logic [15:0] ls,
                           input logic [3:0] idx, input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, val, idx, ls, ps};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_TABLE) begin
      if (idx < TABLE_LEN) thresholds[idx] = val;
    end else begin
      predict_sample(ps, ls);
    end
  endtask

  task automatic send_sample(input logic [15:0] ps, input logic [15:0] ls);
    send_item(MODE_SAMPLE, ps, ls, 4'($urandom), 16'($urandom));
  endtask

  task automatic send_entry(input logic [3:0] idx, input logic [15:0] val);
    send_item(MODE_TABLE, 16'($urandom), 16'($urandom), idx, val);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EXIT) exit_lvl = val;
    else enter_lvl = val;
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[86:0];
      got = {m_tdata[15:0], m_tdata[35:16], m_tdata[51:36], m_tdata[71:52],
             m_tdata[84:72], m_tdata[85], m_tdata[86]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pm=%0d pd=%0d lm=%0d ld=%0d d=%0d n=%0b b=%0b / got pm=%0d pd=%0d lm=%0d ld=%0d d=%0d n=%0b b=%0b",
                     want.prox_mean, want.prox_dev, want.light_mean, want.light_dev,
                     want.distance, want.near_flag, want.blocked_flag,
                     got.prox_mean, got.prox_dev, got.light_mean, got.light_dev,
                     got.distance, got.near_flag, got.blocked_flag);
        end
      end
    end
  end

  // Extreme values, windows filling and wrapping, and an empty table.
  task automatic test_extremes();
    send_sample(16'hffff, 16'hffff);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hffff, 16'h0000);
    for (int i = 0; i < 18; i++) send_sample(16'hffff, 16'hffff);
  endtask

  // Table loads, out-of-range-free index sweep, distance interpolation.
  task automatic test_distance_table();
    for (int i = 0; i < TABLE_LEN; i++) send_entry(4'(i), 16'(60000 - i * 4000));
    send_sample(16'd61000, 16'd5);
    send_sample(16'd30000, 16'd7);
    send_sample(16'd0, 16'd9);
    send_sample(16'd45000, 16'd1);
    send_entry(4'd15, 16'hffff);
    send_entry(4'd0, 16'h0000);
  endtask

  // Hysteresis and blocking with a flat dark light window.
  task automatic test_flags();
    write_reg(REG_EXIT, 16'd1000);
    write_reg(REG_ENTER, 16'd50000);
    for (int i = 0; i < 17; i++) send_sample(16'd100, 16'd0);
    send_sample(16'd50000, 16'd0);
    send_sample(16'd20000, 16'd0);
    send_sample(16'd1000, 16'd0);
    send_sample(16'd60000, 16'd0);
    send_sample(16'd60000, 16'd3);
    send_sample(16'd500, 16'd0);
  endtask

  // Random traffic: samples that are random, near the levels or extreme, and some table writes.
  task automatic test_random(input int count);
    logic [15:0] ps;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 6) begin
        send_entry(4'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(3))
          0: ps = 16'($urandom);
          1: ps = 16'(enter_lvl + $urandom_range(2) - 1);
          2: ps = 16'(exit_lvl + $urandom_range(2) - 1);
          default: ps = $urandom_range(1) ? 16'hffff : 16'h0000;
        endcase
        send_sample(ps, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      prox_ring[i] = '0;
      light_ring[i] = '0;
    end
    for (int i = 0; i < TABLE_LEN; i++) thresholds[i] = '0;
    prox_total = 0;
    light_total = 0;
    ring_ptr = 0;
    seen_count = 0;
    near_st = 0;
    blocked_st = 0;
    exit_lvl = 16'd0;
    enter_lvl = 16'hffff;
    mismatches = 0;
    send_idle_pct = 38;
    recv_idle_pct = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_distance_table();
    test_flags();

    write_reg(REG_EXIT, 16'h0000);
    write_reg(REG_ENTER, 16'hffff);
    test_random(360);
    send_idle_pct = 70;
    recv_idle_pct = 38;
    write_reg(REG_EXIT, 16'hffff);
    write_reg(REG_ENTER, 16'h0000);
    test_random(360);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_EXIT, 16'($urandom_range(30000)));
    write_reg(REG_ENTER, 16'($urandom_range(65535, 30000)));
    test_random(360);

    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[proximity_window_stats_tracker] OK");
    end else begin
      $display("[proximity_window_stats_tracker] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[proximity_window_stats_tracker] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pwst_pkg.sv
src/pwst_arith.sv
src/proximity_window_stats_tracker.sv
src/pwst_checker.sv
bench/tb_proximity_window_stats_tracker.sv
